FILE: rtl/core/rau_pkg.sv
// Package for the rational arithmetic unit: widths, operation codes, sequencer states.
// No dependencies.
package rau_pkg;
   localparam int OPERAND_WIDTH = 32;
   localparam int IN_W  = 32;
   localparam int NUM_W = 64;
   localparam int DEN_W = 63;
   localparam int MAG_W = 63;
   localparam int CNT_W = 6;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_SUM, ST_NORM,
      ST_GCD, ST_DIVN, ST_DIVD, ST_DONE
   } state_type;

   // operand taken from low OPERAND_WIDTH bits, most negative code nudged up by one
   function automatic logic signed [IN_W-1:0] take_operand(input logic [IN_W-1:0] v);
      logic signed [OPERAND_WIDTH-1:0] x;
      logic signed [IN_W-1:0] r;
      x = v[OPERAND_WIDTH-1:0];
      r = IN_W'(x);
      if (x == {1'b1, {(OPERAND_WIDTH-1){1'b0}}}) r = r + IN_W'(1);
      return r;
   endfunction
endpackage

FILE: rtl/core/rau_if.sv
// Valid/ready channel interfaces for the rational arithmetic unit.
// Depends on rau_pkg.
interface rau_req_if import rau_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic signed [IN_W-1:0] a_num;
   logic signed [IN_W-1:0] a_den;
   logic signed [IN_W-1:0] b_num;
   logic signed [IN_W-1:0] b_den;
   modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if import rau_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [NUM_W-1:0] res_num;
   logic [DEN_W-1:0] res_den;
   logic zero_den;
   logic a_less;
   logic a_equal;
   logic a_greater;
   modport source (output valid, res_num, res_den, zero_den, a_less, a_equal, a_greater,
                   input ready);
   modport sink   (input valid, res_num, res_den, zero_den, a_less, a_equal, a_greater,
                   output ready);
endinterface

FILE: rtl/core/rational_arith_unit_top.sv
// Rational arithmetic unit top level: sequencer around one multiplier and a
// restoring shift-subtract divider. Depends on rau_pkg, rau_if.
//
// Usage: a request word carries kind (add, sub, mul, div) and two fractions
// a_num/a_den, b_num/b_den. One response word returns the reduced result
// res_num/res_den, zero_den, and the compare flags a_less/a_equal/a_greater
// taken from the cross products a_num*b_den and b_num*a_den.
// One word is worked on at a time; req_ready is high only when idle.
// Sequence: the multiply states ST_MUL1, ST_MUL2 and ST_MUL3, the setup states
// ST_SUM and ST_NORM, then the Euclid gcd, where each remainder comes from the
// shared shift-subtract divider, then two divisions to reduce numerator and
// denominator; a zero numerator skips gcd and divides. The divider loop
// produces one quotient bit per cycle.
// The response stays in its register until rsp_ready; no new request is
// taken meanwhile. Synchronous reset returns to idle with no word pending.
module rational_arith_unit_top import rau_pkg::*; (
   input logic clock,
   input logic reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);
   state_type state_ff, state_in;
   logic [1:0] kind_ff, kind_in;
   logic signed [IN_W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [IN_W-1:0] an_in, ad_in, bn_in, bd_in;
   logic signed [NUM_W-1:0] left_ff, right_ff, dp_ff, left_in, right_in, dp_in;
   logic signed [NUM_W-1:0] n_ff, n_in;
   logic neg_ff, neg_in;
   logic [MAG_W-1:0] mn_ff, md_ff, x_ff, y_ff, mn_in, md_in, x_in, y_in;
   // divider: dividend shifts out into quotient, rem accumulates
   logic [MAG_W-1:0] q_ff, q_in, r_ff, r_in, dv_ff, dv_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [NUM_W-1:0] mul_res;
   logic signed [IN_W-1:0] ma, mb;
   logic [MAG_W:0] trial;
   logic [MAG_W-1:0] rsh;
   logic signed [NUM_W-1:0] res_num_ff, res_num_in;
   logic [DEN_W-1:0] res_den_ff, res_den_in;
   logic zd_ff, zd_in, lt_ff, lt_in, eq_ff, eq_in, gt_ff, gt_in;

   // shared multiplier operand select
   always_comb begin
      ma = an_ff; mb = bd_ff;
      case (state_ff)
         ST_MUL1: begin ma = an_ff; mb = bd_ff; end
         ST_MUL2: begin
            ma = bn_ff; mb = ad_ff;
         end
         ST_MUL3: begin
            if (kind_ff == OP_DIV) begin ma = ad_ff; mb = bn_ff; end
            else begin ma = ad_ff; mb = bd_ff; end
         end
         default: begin ma = an_ff; mb = bn_ff; end
      endcase
   end
   assign mul_res = NUM_W'(ma) * NUM_W'(mb);

   // one divider step
   always_comb begin
      rsh   = {r_ff[MAG_W-2:0], q_ff[MAG_W-1]};
      trial = {r_ff[MAG_W-1], rsh} - {1'b0, dv_ff};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req.valid) state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_MUL3;
         ST_MUL3: state_in = ST_SUM;
         ST_SUM:  state_in = ST_NORM;
         ST_NORM: state_in = (n_ff == '0 || y_ff == '0) ? ST_DIVN : ST_GCD;
         ST_GCD: begin
            if (cnt_ff == CNT_W'(MAG_W-1) && trial[MAG_W] && rsh == '0)
               state_in = ST_DIVN;
            else if (cnt_ff == CNT_W'(MAG_W-1) && !trial[MAG_W] && trial[MAG_W-1:0] == '0)
               state_in = ST_DIVN;
         end
         ST_DIVN: if (n_ff == '0 || cnt_ff == CNT_W'(MAG_W-1)) state_in = ST_DIVD;
         ST_DIVD: if (n_ff == '0 || cnt_ff == CNT_W'(MAG_W-1)) state_in = ST_DONE;
         ST_DONE: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      kind_in = kind_ff; an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      left_in = left_ff; right_in = right_ff; dp_in = dp_ff; n_in = n_ff;
      neg_in = neg_ff; mn_in = mn_ff; md_in = md_ff; x_in = x_ff; y_in = y_ff;
      q_in = q_ff; r_in = r_ff; dv_in = dv_ff; cnt_in = cnt_ff;
      res_num_in = res_num_ff; res_den_in = res_den_ff;
      zd_in = zd_ff; lt_in = lt_ff; eq_in = eq_ff; gt_in = gt_ff;
      case (state_ff)
         ST_IDLE: begin
            kind_in = req.kind;
            an_in = take_operand(req.a_num); ad_in = take_operand(req.a_den);
            bn_in = take_operand(req.b_num); bd_in = take_operand(req.b_den);
         end
         ST_MUL1: left_in = mul_res;
         ST_MUL2: right_in = mul_res;
         ST_MUL3: dp_in = mul_res;
         ST_SUM: begin
            lt_in = left_ff < right_ff; eq_in = left_ff == right_ff;
            gt_in = left_ff > right_ff;
            case (op_type'(kind_ff))
               OP_ADD: n_in = left_ff + right_ff;
               OP_SUB: n_in = left_ff - right_ff;
               // multiplier holds a_num * b_num in this state
               OP_MUL: n_in = mul_res;
               default: n_in = left_ff;
            endcase
            // flip signs when the denominator is negative
            if (dp_ff < 0) begin
               n_in = -n_in;
               y_in = MAG_W'(-dp_ff);
            end else begin
               y_in = MAG_W'(dp_ff);
            end
            neg_in = n_in < 0;
            x_in = n_in < 0 ? MAG_W'(-n_in) : MAG_W'(n_in);
            mn_in = x_in; md_in = y_in;
         end
         ST_NORM: begin
            q_in = x_ff; dv_in = y_ff; r_in = '0; cnt_in = '0;
            if (y_ff == '0) begin
               dv_in = x_ff; // gcd(x,0)=x
               q_in = mn_ff; r_in = '0;
            end else begin
               dv_in = y_ff;
            end
         end
         ST_GCD: begin
            q_in = {q_ff[MAG_W-2:0], 1'b0};
            r_in = trial[MAG_W] ? rsh : trial[MAG_W-1:0];
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MAG_W-1)) begin
               cnt_in = '0;
               // x,y <- y, x mod y
               if (r_in == '0) begin
                  q_in = mn_ff; r_in = '0; // gcd is dv_ff, keep divisor
               end else begin
                  q_in = dv_ff; dv_in = r_in; r_in = '0;
               end
            end
         end
         ST_DIVN: begin
            if (n_ff == '0) begin
               mn_in = '0;
            end else begin
               q_in = {q_ff[MAG_W-2:0], !trial[MAG_W]};
               r_in = trial[MAG_W] ? rsh : trial[MAG_W-1:0];
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(MAG_W-1)) begin
                  mn_in = q_in; q_in = md_ff; r_in = '0; cnt_in = '0;
               end
            end
         end
         ST_DIVD: begin
            if (n_ff == '0) begin
               md_in = MAG_W'(1);
            end else begin
               q_in = {q_ff[MAG_W-2:0], !trial[MAG_W]};
               r_in = trial[MAG_W] ? rsh : trial[MAG_W-1:0];
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(MAG_W-1)) md_in = q_in;
            end
            if (state_in == ST_DONE) begin
               res_num_in = neg_ff ? -NUM_W'(mn_in) : NUM_W'(mn_in);
               res_den_in = md_in;
               zd_in = md_in == '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      kind_ff <= kind_in; an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      left_ff <= left_in; right_ff <= right_in; dp_ff <= dp_in; n_ff <= n_in;
      neg_ff <= neg_in; mn_ff <= mn_in; md_ff <= md_in; x_ff <= x_in; y_ff <= y_in;
      q_ff <= q_in; r_ff <= r_in; dv_ff <= dv_in; cnt_ff <= cnt_in;
      res_num_ff <= res_num_in; res_den_ff <= res_den_in;
      zd_ff <= zd_in; lt_ff <= lt_in; eq_ff <= eq_in; gt_ff <= gt_in;
   end

   assign req.ready     = state_ff == ST_IDLE;
   assign rsp.valid     = state_ff == ST_DONE;
   assign rsp.res_num   = res_num_ff;
   assign rsp.res_den   = res_den_ff;
   assign rsp.zero_den  = zd_ff;
   assign rsp.a_less    = lt_ff;
   assign rsp.a_equal   = eq_ff;
   assign rsp.a_greater = gt_ff;

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> $onehot({rsp.a_less, rsp.a_equal, rsp.a_greater}))
      else $error("compare flags not one-hot");
   a_zd: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.zero_den == (rsp.res_den == '0)))
      else $error("zero_den mismatch");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.res_num))
      else $error("response dropped");
endmodule
